// File: src/kse_pkg.sv
// ----------------------------------------------------------------------------
// kse_pkg
// Shared types, constants and helper functions for the keypad scanner and
// numeric entry unit.
// ----------------------------------------------------------------------------
package kse_pkg;

    // Keypad geometry and entry limits
    localparam int KEY_ROWS     = 4;
    localparam int MAX_DIGITS   = 9;
    localparam int SCAN_ROWS    = (KEY_ROWS < 4) ? KEY_ROWS : 4;

    localparam int LINE_W       = 4;
    localparam int CHAR_W       = 8;
    localparam int VALUE_W      = 30;
    localparam int COUNT_W      = 4;

    localparam logic [LINE_W-1:0]  ALL_HIGH       = 4'hF;
    localparam logic [COUNT_W-1:0] WANTED_RESET   = 4'd2;

    // Characters with a special meaning
    localparam logic [CHAR_W-1:0]  CH_0           = 8'h30;
    localparam logic [CHAR_W-1:0]  CH_9           = 8'h39;
    localparam logic [CHAR_W-1:0]  CH_CLEAR       = 8'h63;

    // Scan sequencer phases
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ROWS = 2'd1,
        PH_COL  = 2'd2,
        PH_HOLD = 2'd3
    } scan_phase_t;

    // Key released and decoded this tick
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] ch;
    } key_evt_t;

    // Entry accumulator result for one tick
    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] value;
        logic               invalid;
        logic [COUNT_W-1:0] count;
    } entry_res_t;

    // Active-low drive pattern with a single row pulled low
    function automatic logic [LINE_W-1:0] row_low(input logic [1:0] r);
        logic [LINE_W-1:0] one_hot;
        one_hot = 4'b0001 << r;
        return ~one_hot;
    endfunction

    // Lowest numbered column that reads low
    function automatic logic [1:0] first_low_col(input logic [LINE_W-1:0] cols);
        logic [1:0] idx;
        idx = 2'd0;
        for (int i = LINE_W - 1; i >= 0; i--) begin
            if (!cols[i]) begin
                idx = 2'(i);
            end
        end
        return idx;
    endfunction

    // Fixed 4x4 key layout
    function automatic logic [CHAR_W-1:0] key_lookup(input logic [1:0] row,
                                                      input logic [1:0] col);
        logic [CHAR_W-1:0] ch;
        case ({row, col})
            4'h0:    ch = "7";
            4'h1:    ch = "8";
            4'h2:    ch = "9";
            4'h3:    ch = "/";
            4'h4:    ch = "4";
            4'h5:    ch = "5";
            4'h6:    ch = "6";
            4'h7:    ch = "*";
            4'h8:    ch = "1";
            4'h9:    ch = "2";
            4'hA:    ch = "3";
            4'hB:    ch = "-";
            4'hC:    ch = "c";
            4'hD:    ch = "0";
            4'hE:    ch = "=";
            4'hF:    ch = "+";
            default: ch = "0";
        endcase
        return ch;
    endfunction

endpackage

// File: src/kse_scan.sv
// ----------------------------------------------------------------------------
// kse_scan
// Row scan sequencer: finds the pressed row, reads the column, waits for
// release and reports the decoded key.
// ----------------------------------------------------------------------------
module kse_scan (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [3:0]               cols,
    output logic [3:0]               drive,
    output kse_pkg::key_evt_t        key_evt
);
    import kse_pkg::*;

    scan_phase_t       phase_reg, phase_next;
    logic [1:0]        row_reg, row_next;
    logic [CHAR_W-1:0] held_reg, held_next;

    logic              pressed;
    logic              more_rows;
    logic [2:0]        row_inc;

    assign pressed   = (cols != ALL_HIGH);
    assign row_inc   = {1'b0, row_reg} + 3'd1;
    assign more_rows = (row_inc < 3'(SCAN_ROWS));

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        row_next   = row_reg;
        held_next  = held_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (pressed)
                begin
                    row_next   = 2'd0;
                    phase_next = PH_ROWS;
                end
            end
            PH_ROWS:
            begin
                if (pressed)
                begin
                    phase_next = PH_COL;
                end
                else if (more_rows)
                begin
                    row_next = row_inc[1:0];
                end
                else
                begin
                    row_next   = 2'd0;
                    phase_next = PH_IDLE;
                end
            end
            PH_COL:
            begin
                if (pressed)
                begin
                    held_next  = key_lookup(row_reg, first_low_col(cols));
                    phase_next = PH_HOLD;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_HOLD:
            begin
                if (!pressed)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Outputs: row drive for next sample and released key
    always_comb
    begin
        drive   = '0;
        key_evt = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (pressed)
                begin
                    drive = row_low(2'd0);
                end
            end
            PH_ROWS:
            begin
                if (!pressed && more_rows)
                begin
                    drive = row_low(row_inc[1:0]);
                end
            end
            PH_COL:
            begin
                drive = '0;
            end
            PH_HOLD:
            begin
                if (!pressed)
                begin
                    key_evt.valid = 1'b1;
                    key_evt.ch    = held_reg;
                end
            end
            default:
            begin
                drive = '0;
            end
        endcase
    end

    // State registers advance once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            row_reg   <= 2'd0;
            held_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            held_reg  <= held_next;
        end
    end

endmodule

// File: src/kse_entry.sv
// ----------------------------------------------------------------------------
// kse_entry
// Decimal entry accumulator: adds digits, removes the last digit on clear,
// completes at the wanted count and aborts on any other key.
// ----------------------------------------------------------------------------
module kse_entry (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  kse_pkg::key_evt_t        key_evt,
    input  logic [3:0]               wanted,
    output kse_pkg::entry_res_t      res
);
    import kse_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_CNT   = COUNT_W'(MAX_DIGITS);
    // Reciprocal of ten, exact for any 32-bit dividend after a 35-bit shift
    localparam logic [31:0]        RECIP_10  = 32'hCCCC_CCCD;
    localparam int                 PROD_W    = VALUE_W + 32;

    logic [VALUE_W-1:0] sum_reg, sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [COUNT_W-1:0] wanted_clamp;
    logic [COUNT_W-1:0] count_inc;
    logic [VALUE_W-1:0] sum_times_ten;
    logic [VALUE_W-1:0] sum_grown;
    logic [PROD_W-1:0]  div_prod;
    logic [VALUE_W-1:0] sum_tenth;
    logic [3:0]         digit;
    logic               is_digit;

    // Wanted count held to 1..MAX_DIGITS
    always_comb
    begin
        if (wanted == '0)
        begin
            wanted_clamp = COUNT_W'(1);
        end
        else if (wanted > MAX_CNT)
        begin
            wanted_clamp = MAX_CNT;
        end
        else
        begin
            wanted_clamp = wanted;
        end
    end

    // Datapath: append a digit, or drop the last one
    assign is_digit      = key_evt.ch inside {[CH_0:CH_9]};
    assign digit         = 4'(key_evt.ch - CH_0);
    assign count_inc     = count_reg + COUNT_W'(1);
    assign sum_times_ten = (sum_reg << 3) + (sum_reg << 1);
    assign sum_grown     = sum_times_ten + VALUE_W'(digit);
    assign div_prod      = PROD_W'(sum_reg) * PROD_W'(RECIP_10);
    assign sum_tenth     = VALUE_W'(div_prod[PROD_W-1:35]);

    // Entry update on a released key
    always_comb
    begin
        sum_next    = sum_reg;
        count_next  = count_reg;
        res.done    = 1'b0;
        res.value   = '0;
        res.invalid = 1'b0;
        if (key_evt.valid)
        begin
            if (is_digit)
            begin
                if (count_inc >= wanted_clamp)
                begin
                    res.done   = 1'b1;
                    res.value  = sum_grown;
                    sum_next   = '0;
                    count_next = '0;
                end
                else
                begin
                    sum_next   = sum_grown;
                    count_next = count_inc;
                end
            end
            else if (key_evt.ch == CH_CLEAR)
            begin
                if (count_reg != '0)
                begin
                    count_next = count_reg - COUNT_W'(1);
                    sum_next   = sum_tenth;
                end
            end
            else
            begin
                res.done    = 1'b1;
                res.invalid = 1'b1;
                sum_next    = '0;
                count_next  = '0;
            end
        end
        res.count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: src/keypad_scan_numeric_entry_unit.sv
// ----------------------------------------------------------------------------
// keypad_scan_numeric_entry_unit
// 4x4 matrix keypad scanner with decimal numeric entry, one scan tick per
// input transfer and one result transfer per tick.
// ----------------------------------------------------------------------------
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------
//   input    | in_valid/in_ready   | col_sense
//   result   | out_valid/out_ready | row_drive, key_valid, key_char,
//            |                     | entry_done, entry_value, entry_invalid,
//            |                     | digits_entered
//   config   | cfg_valid/cfg_ready | cfg_data (digits_wanted)
//
// A tick is taken into the input register, then processed into the result
// register once it is empty or being read; one tick per cycle is sustained
// while out_ready stays high. The input register can take a new tick while
// the previous result waits. The step logic (scan sequencer and decimal
// accumulator with a constant-reciprocal divide by ten) sets the cycle.
// Reset clears the scan state, entry and valid flags; digits_wanted returns
// to 2. A stalled result holds the input register full and drops in_ready.
//
module keypad_scan_numeric_entry_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    // Scan ticks
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  col_sense,
    // Results
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  row_drive,
    output logic        key_valid,
    output logic [7:0]  key_char,
    output logic        entry_done,
    output logic [29:0] entry_value,
    output logic        entry_invalid,
    output logic [3:0]  digits_entered
);
    import kse_pkg::*;

    logic [COUNT_W-1:0] wanted_reg;
    logic               in_full_reg;
    logic [LINE_W-1:0]  col_reg;
    logic               out_valid_reg;

    logic [LINE_W-1:0]  row_drive_reg;
    key_evt_t           key_reg;
    entry_res_t         res_reg;

    logic               advance;
    logic [LINE_W-1:0]  drive_next;
    key_evt_t           key_evt;
    entry_res_t         res_next;

    // Configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_reg <= WANTED_RESET;
        end
        else if (cfg_valid)
        begin
            wanted_reg <= cfg_data;
        end
    end

    // Pipeline control
    assign advance  = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_full_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_full_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            col_reg <= col_sense;
        end
    end

    // Step logic
    kse_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .cols    (col_reg),
        .drive   (drive_next),
        .key_evt (key_evt)
    );

    kse_entry u_entry (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .key_evt (key_evt),
        .wanted  (wanted_reg),
        .res     (res_next)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            row_drive_reg <= drive_next;
            key_reg       <= key_evt;
            res_reg       <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign row_drive      = row_drive_reg;
    assign key_valid      = key_reg.valid;
    assign key_char       = key_reg.ch;
    assign entry_done     = res_reg.done;
    assign entry_value    = res_reg.value;
    assign entry_invalid  = res_reg.invalid;
    assign digits_entered = res_reg.count;

endmodule

// File: src/kse_checker.sv
// ----------------------------------------------------------------------------
// kse_checker
// Port-level checks on the keypad entry unit, bound to the top level.
// ----------------------------------------------------------------------------
module kse_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [3:0]  row_drive,
    input  logic        key_valid,
    input  logic [7:0]  key_char,
    input  logic        entry_done,
    input  logic [29:0] entry_value,
    input  logic        entry_invalid,
    input  logic [3:0]  digits_entered
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(key_char)
            && $stable(entry_value) && $stable(digits_entered))
        else $error("result changed while stalled");

    // No character without a released key
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !key_valid |-> key_char == 8'h00 && !entry_done)
        else $error("character or entry end without a key");

    // Aborted entry carries a zero value
    a_abort_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_invalid |-> entry_done && entry_value == 30'd0)
        else $error("aborted entry with a value");

    // A completed or aborted entry leaves no digits, and the count stays in range
    a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> digits_entered <= 4'd9
            && (!entry_done || digits_entered == 4'd0))
        else $error("digit count wrong");

    // Rows are all low or exactly one low
    a_row_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> row_drive == 4'h0 || $onehot(~row_drive))
        else $error("bad row drive pattern");

endmodule

bind keypad_scan_numeric_entry_unit kse_checker u_kse_checker (.*);
